### design/gzhp_pkg.sv
// Package for the gzip member header parser.
// Holds the parse phase encoding, status codes, parser state type and CRC-32 helpers.
// No dependencies.
`default_nettype none

package gzhp_pkg;

  // Parse phases, one-hot
  typedef enum logic [7:0] {
    PH_FIXED   = 8'b0000_0001,
    PH_XLEN0   = 8'b0000_0010,
    PH_XLEN1   = 8'b0000_0100,
    PH_EXTRA   = 8'b0000_1000,
    PH_NAME    = 8'b0001_0000,
    PH_COMMENT = 8'b0010_0000,
    PH_HCRC0   = 8'b0100_0000,
    PH_HCRC1   = 8'b1000_0000
  } gzhp_phase_t;

  // Result status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Header flag bits
  localparam int FL_HCRC    = 1;
  localparam int FL_EXTRA   = 2;
  localparam int FL_NAME    = 3;
  localparam int FL_COMMENT = 4;

  // Optional field stages, in header order
  localparam logic [2:0] STG_EXTRA   = 3'd0;
  localparam logic [2:0] STG_NAME    = 3'd1;
  localparam logic [2:0] STG_COMMENT = 3'd2;
  localparam logic [2:0] STG_HCRC    = 3'd3;
  localparam logic [2:0] STG_END     = 3'd4;

  // Fixed header constants
  localparam logic [7:0]  MAGIC0       = 8'h1F;
  localparam logic [7:0]  MAGIC1       = 8'h8B;
  localparam logic [7:0]  METHOD_DEFL  = 8'h08;
  localparam logic [7:0]  FLG_RSVD     = 8'hE0;
  localparam logic [31:0] MIN_LENGTH   = 32'd18;
  localparam logic [32:0] XLEN_MARGIN  = 33'd12;
  localparam logic [32:0] TRAILER_LEN  = 33'd8;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

  // Per-stream parser state
  typedef struct packed {
    logic [31:0] pos;
    gzhp_phase_t phase;
    logic [4:0]  flags;
    logic [15:0] xrem;
    logic [31:0] crc;
    logic [31:0] tval;
    logic [7:0]  scrc;
    logic [1:0]  fin;
  } gzhp_state_t;

  localparam gzhp_state_t STATE_RESTART = '{
    pos:   32'd0,
    phase: PH_FIXED,
    flags: 5'd0,
    xrem:  16'd0,
    crc:   CRC_INIT,
    tval:  32'd0,
    scrc:  8'd0,
    fin:   ST_BUSY
  };

  // Reflected CRC-32 nibble table
  function automatic logic [31:0] crc_nib(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'h0: v = 32'h0000_0000;
      4'h1: v = 32'h1DB7_1064;
      4'h2: v = 32'h3B6E_20C8;
      4'h3: v = 32'h26D9_30AC;
      4'h4: v = 32'h76DC_4190;
      4'h5: v = 32'h6B6B_51F4;
      4'h6: v = 32'h4DB2_6158;
      4'h7: v = 32'h5005_713C;
      4'h8: v = 32'hEDB8_8320;
      4'h9: v = 32'hF00F_9344;
      4'hA: v = 32'hD6D6_A3E8;
      4'hB: v = 32'hCB61_B38C;
      4'hC: v = 32'h9B64_C2B0;
      4'hD: v = 32'h86D3_D2D4;
      4'hE: v = 32'hA00A_E278;
      4'hF: v = 32'hBDBD_F21C;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  // Advance the CRC-32 by one byte, two nibbles at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = crc_nib(c[3:0]) ^ (c >> 4);
    c = crc_nib(c[3:0]) ^ (c >> 4);
    return c;
  endfunction

endpackage

`default_nettype wire

### design/gzhp_step.sv
// Next-state logic of the gzip header parser for one stream byte.
// Depends on gzhp_pkg (phase type, state struct, CRC helpers).
`default_nettype none

module gzhp_step import gzhp_pkg::*; (
  input  var gzhp_state_t st_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        first_i,
  input  wire logic [31:0] len_i,
  output var gzhp_state_t st_o,
  output logic             name_valid_o,
  output logic [7:0]       name_byte_o
);

  typedef struct packed {
    gzhp_phase_t phase;
    logic [1:0]  fin;
  } gzhp_enter_t;

  // Pick the next present optional field, or close the header
  function automatic gzhp_enter_t enter_stage(
    input logic [2:0]  stage,
    input logic [4:0]  flags,
    input gzhp_phase_t phase,
    input logic [31:0] pos,
    input logic [31:0] len
  );
    gzhp_enter_t r;
    r.phase = phase;
    r.fin   = ST_BUSY;
    if (stage <= STG_EXTRA && flags[FL_EXTRA]) begin
      r.phase = PH_XLEN0;
    end else if (stage <= STG_NAME && flags[FL_NAME]) begin
      r.phase = PH_NAME;
    end else if (stage <= STG_COMMENT && flags[FL_COMMENT]) begin
      r.phase = PH_COMMENT;
    end else if (stage <= STG_HCRC && flags[FL_HCRC]) begin
      r.phase = PH_HCRC0;
    end else if ({1'b0, pos} + TRAILER_LEN > {1'b0, len}) begin
      r.fin = ST_ERR;
    end else begin
      r.fin = ST_OK;
    end
    return r;
  endfunction

  gzhp_state_t cur;
  gzhp_enter_t es;
  logic [31:0] p1;
  logic [31:0] crc_b;
  logic [15:0] xr;
  logic        err;

  always_comb begin
    // Restart on the first byte of a stream
    cur = first_i ? STATE_RESTART : st_i;
    st_o = cur;
    name_valid_o = 1'b0;
    name_byte_o  = 8'd0;
    p1    = cur.pos + 32'd1;
    crc_b = crc_byte(cur.crc, byte_i);
    xr    = 16'd0;
    err   = 1'b0;
    es    = '{phase: cur.phase, fin: ST_BUSY};

    if (cur.fin == ST_BUSY) begin
      case (cur.phase)
        PH_FIXED: begin
          if (cur.pos == 32'd0 && (len_i < MIN_LENGTH || byte_i != MAGIC0)) begin
            err = 1'b1;
          end else if (cur.pos == 32'd1 && byte_i != MAGIC1) begin
            err = 1'b1;
          end else if (cur.pos == 32'd2 && byte_i != METHOD_DEFL) begin
            err = 1'b1;
          end else if (cur.pos == 32'd3) begin
            if ((byte_i & FLG_RSVD) != 8'd0) begin
              err = 1'b1;
            end else begin
              st_o.flags = byte_i[4:0];
            end
          end else if (cur.pos >= 32'd4 && cur.pos <= 32'd7) begin
            st_o.tval = cur.tval | ({24'd0, byte_i} << {cur.pos[1:0], 3'b000});
          end
          if (err) begin
            st_o.fin = ST_ERR;
          end else begin
            st_o.crc = crc_b;
            st_o.pos = p1;
            if (cur.pos >= 32'd9) begin
              es = enter_stage(STG_EXTRA, st_o.flags, cur.phase, p1, len_i);
              st_o.phase = es.phase;
              st_o.fin   = es.fin;
            end
          end
        end
        PH_XLEN0: begin
          st_o.xrem  = {8'd0, byte_i};
          st_o.crc   = crc_b;
          st_o.pos   = p1;
          st_o.phase = PH_XLEN1;
        end
        PH_XLEN1: begin
          xr = {byte_i, cur.xrem[7:0]};
          st_o.xrem = xr;
          if ({17'd0, xr} + XLEN_MARGIN > {1'b0, len_i}) begin
            st_o.fin = ST_ERR;
          end else begin
            st_o.crc = crc_b;
            st_o.pos = p1;
            if (xr == 16'd0) begin
              es = enter_stage(STG_NAME, cur.flags, cur.phase, p1, len_i);
              st_o.phase = es.phase;
              st_o.fin   = es.fin;
            end else begin
              st_o.phase = PH_EXTRA;
            end
          end
        end
        PH_EXTRA: begin
          xr = cur.xrem - 16'd1;
          st_o.xrem = xr;
          st_o.crc  = crc_b;
          st_o.pos  = p1;
          if (xr == 16'd0) begin
            es = enter_stage(STG_NAME, cur.flags, cur.phase, p1, len_i);
            st_o.phase = es.phase;
            st_o.fin   = es.fin;
          end
        end
        PH_NAME, PH_COMMENT: begin
          if (cur.pos >= len_i) begin
            st_o.fin = ST_ERR;
          end else begin
            if (cur.phase == PH_NAME) begin
              name_valid_o = 1'b1;
              name_byte_o  = byte_i;
            end
            st_o.crc = crc_b;
            st_o.pos = p1;
            if (byte_i == 8'd0) begin
              es = enter_stage((cur.phase == PH_NAME) ? STG_COMMENT : STG_HCRC,
                               cur.flags, cur.phase, p1, len_i);
              st_o.phase = es.phase;
              st_o.fin   = es.fin;
            end
          end
        end
        PH_HCRC0: begin
          if ({1'b0, cur.pos} + 33'd2 > {1'b0, len_i}) begin
            st_o.fin = ST_ERR;
          end else begin
            st_o.scrc  = byte_i;
            st_o.pos   = p1;
            st_o.phase = PH_HCRC1;
          end
        end
        PH_HCRC1: begin
          // Stored CRC16 must match the low half of the finished CRC-32
          if ({byte_i, cur.scrc} != ~cur.crc[15:0]) begin
            st_o.fin = ST_ERR;
          end else begin
            st_o.pos = p1;
            es = enter_stage(STG_END, cur.flags, cur.phase, p1, len_i);
            st_o.phase = es.phase;
            st_o.fin   = es.fin;
          end
        end
        default: begin
          st_o.fin = ST_ERR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/gzip_header_parser.sv
// Top level of the gzip member header parser: stream ports, input and result registers.
// Depends on gzhp_pkg and gzhp_step.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+---------------------------------------------
//  in      | in  | in_tvalid/tready   | tdata: data_byte; tuser: first_byte
//  out     | out | out_tvalid/tready  | tdata: status, header_length, mod_time,
//          |     |                    |        name_byte; tuser: name_valid
//  cfg     | in  | cfg_valid/ready    | cfg_data: source_length
//
// One word per cycle while the result channel is not stalled; each word passes
// through the input register, then the parser step into the result register. The
// per-byte CRC and position update lies between the two registers.
// Reset (rst_n low, synchronous) empties both registers, clears source_length
// and puts the parser at offset zero of a new stream.
// A stalled result holds; the input register fills next, then in_tready drops.
`default_nettype none

module gzip_header_parser import gzhp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] first_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [1:0] status, [33:2] header_length,
                                       // [65:34] mod_time, [73:66] name_byte, zeros
  output logic [0:0]       out_tuser,  // [0] name_valid
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data    // source_length
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_first_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_hlen_r;
  logic [31:0] out_time_r;
  logic        out_nvalid_r;
  logic [7:0]  out_nbyte_r;
  logic [31:0] len_r;
  gzhp_state_t st_r;
  gzhp_state_t st_nxt;
  logic        nvalid_nxt;
  logic [7:0]  nbyte_nxt;
  logic        adv;
  logic        fire;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  // Hold source_length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  // Capture input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser[0];
    end
  end

  gzhp_step u_step (
    .st_i         (st_r),
    .byte_i       (in_byte_r),
    .first_i      (in_first_r),
    .len_i        (len_r),
    .st_o         (st_nxt),
    .name_valid_o (nvalid_nxt),
    .name_byte_o  (nbyte_nxt)
  );

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESTART;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= st_nxt.fin;
      out_hlen_r   <= (st_nxt.fin == ST_OK) ? st_nxt.pos : 32'd0;
      out_time_r   <= st_nxt.tval;
      out_nvalid_r <= nvalid_nxt;
      out_nbyte_r  <= nbyte_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_nbyte_r, out_time_r, out_hlen_r, out_status_r};
  assign out_tuser  = out_nvalid_r;

  // Status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("unused status code on output");

  // Header length only reported with a valid header
  a_hlen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != ST_OK) |-> out_tdata[33:2] == 32'd0)
    else $error("header length without ok status");

  // A finished parse ignores bytes until a restart
  a_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_first_r && st_r.fin != ST_BUSY) |=> $stable(st_r))
    else $error("parser state moved after completion");

  // An empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

### tb/gzhp_checker.sv
// Checker for the gzip member header parser: watches the config, input and result channels.
// Predicts every result word from its own parser state and compares it with the block.
// Depends on gzhp_pkg for phase, status, flag and header constants.
`timescale 1ns / 1ps

module gzhp_checker import gzhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] first_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,  // [1:0] status, [33:2] header_length,
                                  // [65:34] mod_time, [73:66] name_byte, zeros
  input  logic [0:0]  out_tuser,  // [0] name_valid
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,   // source_length
  output int          results_due,
  output int          fail_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hdr_len;
    logic [31:0] mtime;
    logic        name_valid;
    logic [7:0]  name_byte;
  } parse_result_t;

  parse_result_t status_due[$];
  parse_result_t want, got;
  int fails = 0;

  // Mirror of the parser state and the length register
  logic [31:0] src_len;
  logic [31:0] pos;
  gzhp_phase_t phase;
  logic [4:0]  flags;
  logic [15:0] xrem;
  logic [31:0] crc;
  logic [31:0] tval;
  logic [7:0]  crc_lo;
  logic [1:0]  latch;

  // Bitwise reflected CRC-32, one byte
  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int i;
    r = c ^ {24'd0, b};
    for (i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    return r;
  endfunction

  task automatic clear_parse();
    pos    = '0;
    phase  = PH_FIXED;
    flags  = '0;
    xrem   = '0;
    crc    = 32'hFFFF_FFFF;
    tval   = '0;
    crc_lo = '0;
    latch  = ST_BUSY;
  endtask

  // Move to the next optional field present from the given stage on, else close the header
  task automatic next_field(input logic [2:0] stage);
    if (stage <= STG_EXTRA && flags[FL_EXTRA]) phase = PH_XLEN0;
    else if (stage <= STG_NAME && flags[FL_NAME]) phase = PH_NAME;
    else if (stage <= STG_COMMENT && flags[FL_COMMENT]) phase = PH_COMMENT;
    else if (stage <= STG_HCRC && flags[FL_HCRC]) phase = PH_HCRC0;
    else latch = ({1'b0, pos} + TRAILER_LEN > {1'b0, src_len}) ? ST_ERR : ST_OK;
  endtask

  // Advance the parse by one stream byte and form the result word it causes
  task automatic parse_header_byte(input logic [7:0] b, input logic first,
                                   output parse_result_t r);
    logic [31:0] p;
    logic        nv;
    logic [7:0]  nb;
    nv = 1'b0;
    nb = 8'd0;
    if (first) clear_parse();
    if (latch == ST_BUSY) begin
      p = pos;
      case (phase)
        PH_FIXED: begin
          if (p == 0 && (src_len < MIN_LENGTH || b != MAGIC0)) latch = ST_ERR;
          else if (p == 1 && b != MAGIC1) latch = ST_ERR;
          else if (p == 2 && b != METHOD_DEFL) latch = ST_ERR;
          else if (p == 3) begin
            if ((b & FLG_RSVD) != 8'd0) latch = ST_ERR;
            else flags = b[4:0];
          end else if (p >= 4 && p <= 7) begin
            tval = tval | ({24'd0, b} << (8 * (p - 4)));
          end
          if (latch == ST_BUSY) begin
            crc = crc32_next(crc, b);
            pos = p + 1;
            if (p >= 9) next_field(STG_EXTRA);
          end
        end
        PH_XLEN0: begin
          xrem  = {8'd0, b};
          crc   = crc32_next(crc, b);
          pos   = p + 1;
          phase = PH_XLEN1;
        end
        PH_XLEN1: begin
          xrem = {b, xrem[7:0]};
          if ({17'd0, xrem} + XLEN_MARGIN > {1'b0, src_len}) begin
            latch = ST_ERR;
          end else begin
            crc = crc32_next(crc, b);
            pos = p + 1;
            if (xrem == 16'd0) next_field(STG_NAME);
            else phase = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          crc  = crc32_next(crc, b);
          pos  = p + 1;
          xrem = xrem - 16'd1;
          if (xrem == 16'd0) next_field(STG_NAME);
        end
        PH_NAME, PH_COMMENT: begin
          // bytes past the stream end are an error and are not emitted
          if (p >= src_len) begin
            latch = ST_ERR;
          end else begin
            if (phase == PH_NAME) begin
              nv = 1'b1;
              nb = b;
            end
            crc = crc32_next(crc, b);
            pos = p + 1;
            if (b == 8'd0) next_field((phase == PH_NAME) ? STG_COMMENT : STG_HCRC);
          end
        end
        PH_HCRC0: begin
          if ({1'b0, p} + 33'd2 > {1'b0, src_len}) begin
            latch = ST_ERR;
          end else begin
            crc_lo = b;
            pos    = p + 1;
            phase  = PH_HCRC1;
          end
        end
        PH_HCRC1: begin
          if ({b, crc_lo} != ~crc[15:0]) begin
            latch = ST_ERR;
          end else begin
            pos = p + 1;
            next_field(STG_END);
          end
        end
        default: latch = ST_ERR;
      endcase
    end
    r.status     = latch;
    r.hdr_len    = (latch == ST_OK) ? pos : 32'd0;
    r.mtime      = tval;
    r.name_valid = nv;
    r.name_byte  = nb;
  endtask

  // Track register writes, predict on accepted input words, compare accepted result words
  always @(posedge clk) begin
    if (!rst_n) begin
      src_len = '0;
      clear_parse();
      status_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) src_len = cfg_data;
      if (in_tvalid && in_tready) begin
        parse_header_byte(in_tdata, in_tuser[0], want);
        status_due = {status_due, want};
      end
      if (out_tvalid && out_tready) begin
        got.status     = out_tdata[1:0];
        got.hdr_len    = out_tdata[33:2];
        got.mtime      = out_tdata[65:34];
        got.name_byte  = out_tdata[73:66];
        got.name_valid = out_tuser[0];
        if (status_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result word with none due: status %0d len %0d time %h name %0b/%h",
                     $realtime, got.status, got.hdr_len, got.mtime, got.name_valid,
                     got.name_byte);
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $write("%0t: result mismatch: expected status %0d len %0d time %h name %0b/%h,",
                     $realtime, want.status, want.hdr_len, want.mtime, want.name_valid,
                     want.name_byte);
              $display(" got status %0d len %0d time %h name %0b/%h",
                       got.status, got.hdr_len, got.mtime, got.name_valid, got.name_byte);
            end
          end
        end
      end
    end
    results_due <= status_due.size();
    fail_count  <= fails;
  end

endmodule

### tb/tb_top.sv
// Top of the gzip header parser testbench: clock, reset, stimulus and verdict.
// Builds gzip headers (well-formed and broken), drives them with random gaps and stalls.
// Depends on gzhp_pkg, gzip_header_parser and gzhp_checker.
`timescale 1ns / 1ps

module tb_top import gzhp_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'd0;

  int          results_due;
  int          fail_count;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          fed = 0;
  logic [31:0] cur_len = 32'd0;
  logic [7:0]  hdr_bytes[$];

  always #2 clk = ~clk;

  gzip_header_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  gzhp_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int i;
    r = c ^ {24'd0, b};
    for (i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    return r;
  endfunction

  // Append one byte to the header under construction
  task automatic add_byte(input logic [7:0] b);
    hdr_bytes = {hdr_bytes, b};
  endtask

  // Send one input word, idling first at random
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fed++;
  endtask

  // Hold the input until every due result word has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_length(input logic [31:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_len = v;
  endtask

  // Build a well-formed member header with the given flags and field sizes
  task automatic build_header(input logic [4:0] flg, input int xlen, input int name_n,
                              input int cmt_n, input logic [31:0] mtime);
    logic [31:0] c;
    int i;
    hdr_bytes.delete();
    add_byte(MAGIC0);
    add_byte(MAGIC1);
    add_byte(METHOD_DEFL);
    add_byte({3'b000, flg});
    for (i = 0; i < 4; i++) add_byte(mtime[8*i +: 8]);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    if (flg[FL_EXTRA]) begin
      add_byte(8'(xlen));
      add_byte(8'(xlen >> 8));
      repeat (xlen) add_byte(8'($urandom));
    end
    if (flg[FL_NAME]) begin
      repeat (name_n) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end
    if (flg[FL_COMMENT]) begin
      repeat (cmt_n) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end
    if (flg[FL_HCRC]) begin
      c = 32'hFFFF_FFFF;
      for (i = 0; i < hdr_bytes.size(); i++) c = crc32_feed(c, hdr_bytes[i]);
      c = ~c;
      add_byte(c[7:0]);
      add_byte(c[15:8]);
    end
  endtask

  // One stream: mostly well-formed headers, some broken, truncated or pure noise
  task automatic one_stream();
    logic [4:0]  flg;
    logic [31:0] len, late_len;
    int xlen, hlen, mode, cut, split, idx, i;
    flg  = 5'($urandom);
    xlen = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 4);
    build_header(flg, xlen, $urandom_range(0, 5), $urandom_range(0, 5), $urandom);
    hlen     = hdr_bytes.size();
    mode     = $urandom_range(99);
    cut      = hlen;
    split    = 0;
    len      = hlen + 8 + $urandom_range(0, 3);
    late_len = len;
    if (mode < 65) begin
      if (cur_len >= hlen + 8 && $urandom_range(2) != 0) len = cur_len;
      else if ($urandom_range(19) == 0) len = 32'hFFFF_FFFF;
    end else if (mode < 70) begin
      // trailer one byte short
      len = hlen + 7;
    end else if (mode < 78) begin
      // stream too short for the header or for its trailer
      len = $urandom_range(0, hlen + 7);
    end else if (mode < 85) begin
      idx = $urandom_range(0, hlen - 1);
      hdr_bytes[idx] = hdr_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
    end else if (mode < 88) begin
      hdr_bytes[3] = hdr_bytes[3] | (8'h20 << $urandom_range(0, 2));
    end else if (mode < 93) begin
      // cut off, the next stream restarts the parse
      cut = $urandom_range(1, hlen - 1);
    end else if (mode < 97) begin
      // change the length while the header is half parsed
      split    = $urandom_range(1, hlen - 1);
      late_len = $urandom_range(0, 1) ? hlen + 8 : $urandom_range(0, hlen + 8);
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(3) == 0);
      return;
    end
    if (len != cur_len) set_length(len);
    for (i = 0; i < cut; i++) begin
      if (split != 0 && i == split) set_length(late_len);
      send_byte(hdr_bytes[i], i == 0);
    end
    // body bytes after the header, ignored once the header is done
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int ph;
    int goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Zero length, parsed from offset zero without a restart flag
    set_length(32'd0);
    send_byte(MAGIC0, 1'b0);
    // One below the minimum length
    set_length(MIN_LENGTH - 1);
    send_byte(MAGIC0, 1'b1);
    // Bad magic, bad method, reserved flag bit
    set_length(32'hFFFF_FFFF);
    send_byte(MAGIC0 ^ 8'h01, 1'b1);
    send_byte(MAGIC0, 1'b1);
    send_byte(MAGIC1 ^ 8'h80, 1'b0);
    send_byte(MAGIC0, 1'b1);
    send_byte(MAGIC1, 1'b0);
    send_byte(METHOD_DEFL ^ 8'h01, 1'b0);
    send_byte(MAGIC0, 1'b1);
    send_byte(MAGIC1, 1'b0);
    send_byte(METHOD_DEFL, 1'b0);
    send_byte(8'h80, 1'b0);
    // Every optional field, empty extra field and empty name and comment
    build_header((5'd1 << FL_EXTRA) | (5'd1 << FL_NAME) | (5'd1 << FL_COMMENT) |
                 (5'd1 << FL_HCRC), 0, 0, 0, 32'hFFFF_FFFF);
    foreach (hdr_bytes[k]) send_byte(hdr_bytes[k], k == 0);

    // Random streams over the idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      goal = fed + 180;
      while (fed < goal) one_stream();
      wait_idle();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
